// ===== rtl/frc_pkg.sv =====
// Shared types and constants for the radio frame receiver.
package frc_pkg;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_DATA  = 2'd2,
    PH_READY = 2'd3
  } phase_t;

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Event codes on the result channel
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_HDR_OK    = 3'd1,
    EV_HDR_BAD   = 3'd2,
    EV_FRAME_OK  = 3'd3,
    EV_FRAME_BAD = 3'd4,
    EV_SYNC_LOST = 3'd5
  } event_t;

  // Sync sequence
  localparam logic [7:0] SYNC0 = 8'h48;
  localparam logic [7:0] SYNC1 = 8'h65;
  localparam logic [7:0] SYNC2 = 8'h20;
  localparam logic [7:0] SYNC3 = 8'h04;

  // Running sums after the last two sync bytes have been folded in
  localparam logic [7:0] SUM_A_SYNC = 8'(SYNC2 + SYNC3);
  localparam logic [7:0] SUM_B_SYNC = 8'(SYNC2 + SUM_A_SYNC);

  // Header length field plus trailing pair
  localparam int LEN_W = 17;

  // Field widths fixed by the port list
  localparam int OP_W   = 2;
  localparam int IDX_W  = 9;
  localparam int PLEN_W = 9;

  // Per-transaction result from the parser
  typedef struct packed {
    event_t ev;
    logic   ready;
  } frc_result_t;

  // Parser status for checks at the top level
  typedef struct packed {
    phase_t phase;
    logic   ready_flag;
    logic   recv_below_exp;
  } frc_status_t;

endpackage

// ===== rtl/frc_payload_ram.sv =====
// Payload byte store: one write port, one registered read port.
module frc_payload_ram import frc_pkg::*; #(
  parameter int DEPTH  = 258,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/frc_parser.sv =====
// Frame parser: sync hunt, header check, payload count and running checksum.
module frc_parser import frc_pkg::*; #(
  parameter int BUFFER_BYTES = 258,
  parameter int CNT_W        = 9,
  parameter int ADDR_W       = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [OP_W-1:0]   operation,
  input  logic [7:0]        rx_byte,
  output frc_result_t       result,
  output logic [CNT_W-1:0]  exp_next,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output frc_status_t       status
);

  phase_t           phase, phase_next;
  logic [3:0]       header_count, header_count_next;
  logic [CNT_W-1:0] expected_count;
  logic [CNT_W-1:0] received_count, received_count_next;
  logic [7:0]       sum_a, sum_a_next;
  logic [7:0]       sum_b, sum_b_next;
  logic             ready_flag, ready_flag_next;

  // Header bytes that are read back, and the first trailing checksum byte
  logic [7:0] len_hi, len_lo, hdr_chk_a, data_chk_a;
  logic       len_hi_we, len_lo_we, hdr_chk_we, data_chk_we;

  logic [LEN_W-1:0] frame_len;
  logic [7:0]       hdr_a2, hdr_b2;
  logic [31:0]      recv_ext, exp_ext;
  event_t           ev;

  assign frame_len = LEN_W'({len_hi, len_lo}) + LEN_W'(2);
  // Sums after folding in the first byte of the header checksum pair
  assign hdr_a2    = sum_a + hdr_chk_a;
  assign hdr_b2    = sum_b + hdr_a2;
  assign recv_ext  = 32'(received_count);
  assign exp_ext   = 32'(expected_count);

  // Next state and outputs
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    exp_next            = expected_count;
    received_count_next = received_count;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    ready_flag_next     = ready_flag;
    ev                  = EV_NONE;
    len_hi_we           = 1'b0;
    len_lo_we           = 1'b0;
    hdr_chk_we          = 1'b0;
    data_chk_we         = 1'b0;
    wr_en               = 1'b0;

    unique case (operation)
      OP_BYTE: begin
        unique case (phase)
          PH_HUNT: begin
            if (rx_byte == SYNC0) begin
              header_count_next = 4'd1;
            end else if (header_count == 4'd1 && rx_byte == SYNC1) begin
              header_count_next = 4'd2;
            end else if (header_count == 4'd2 && rx_byte == SYNC2) begin
              header_count_next = 4'd3;
            end else if (header_count == 4'd3 && rx_byte == SYNC3) begin
              header_count_next = 4'd4;
              sum_a_next        = SUM_A_SYNC;
              sum_b_next        = SUM_B_SYNC;
              phase_next        = PH_HEAD;
            end else begin
              ev                  = (header_count != 4'd0) ? EV_SYNC_LOST : EV_NONE;
              header_count_next   = 4'd0;
              exp_next            = '0;
              received_count_next = '0;
              sum_a_next          = 8'd0;
              sum_b_next          = 8'd0;
            end
          end
          PH_HEAD: begin
            if (header_count[2:0] < 3'd6) begin
              // Length bytes go into the header sum
              len_hi_we         = (header_count[2:0] == 3'd4);
              len_lo_we         = (header_count[2:0] == 3'd5);
              sum_a_next        = sum_a + rx_byte;
              sum_b_next        = sum_b + sum_a + rx_byte;
              header_count_next = {1'b0, header_count[2:0] + 3'd1};
            end else if (header_count[2:0] == 3'd6) begin
              hdr_chk_we        = 1'b1;
              header_count_next = 4'd7;
            end else begin
              header_count_next = 4'd8;
              if (hdr_chk_a == sum_a && rx_byte == sum_b &&
                  32'(frame_len) <= BUFFER_BYTES) begin
                sum_a_next          = hdr_a2 + rx_byte;
                sum_b_next          = hdr_b2 + hdr_a2 + rx_byte;
                exp_next            = CNT_W'(frame_len);
                received_count_next = '0;
                phase_next          = PH_DATA;
                ev                  = EV_HDR_OK;
              end else begin
                ev                  = EV_HDR_BAD;
                phase_next          = PH_HUNT;
                header_count_next   = 4'd0;
                exp_next            = '0;
                received_count_next = '0;
                sum_a_next          = 8'd0;
                sum_b_next          = 8'd0;
              end
            end
          end
          PH_DATA: begin
            if (received_count < expected_count) begin
              wr_en               = 1'b1;
              received_count_next = received_count + CNT_W'(1);
              // Trailing checksum pair stays out of the sum
              if (recv_ext + 32'd2 < exp_ext) begin
                sum_a_next = sum_a + rx_byte;
                sum_b_next = sum_b + sum_a + rx_byte;
              end
              data_chk_we = (recv_ext + 32'd2 == exp_ext);
            end
            if (recv_ext + 32'd1 >= exp_ext) begin
              if (data_chk_a == sum_a && rx_byte == sum_b) begin
                ready_flag_next = 1'b1;
                phase_next      = PH_READY;
                ev              = EV_FRAME_OK;
              end else begin
                ev                  = EV_FRAME_BAD;
                phase_next          = PH_HUNT;
                header_count_next   = 4'd0;
                exp_next            = '0;
                received_count_next = '0;
                sum_a_next          = 8'd0;
                sum_b_next          = 8'd0;
              end
            end
          end
          PH_READY: begin
            ev = EV_NONE;
          end
          default: begin
            ev = EV_NONE;
          end
        endcase
      end
      OP_CLEAR: begin
        phase_next          = PH_HUNT;
        header_count_next   = 4'd0;
        exp_next            = '0;
        received_count_next = '0;
        sum_a_next          = 8'd0;
        sum_b_next          = 8'd0;
        ready_flag_next     = 1'b0;
      end
      default: begin
        ev = EV_NONE;
      end
    endcase
  end

  assign wr_addr = received_count[ADDR_W-1:0];
  assign wr_data = rx_byte;

  assign result.ev    = ev;
  assign result.ready = ready_flag_next;

  assign status.phase          = phase;
  assign status.ready_flag     = ready_flag;
  assign status.recv_below_exp = (received_count < expected_count);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_count   <= 4'd0;
      expected_count <= '0;
      received_count <= '0;
      sum_a          <= 8'd0;
      sum_b          <= 8'd0;
      ready_flag     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      expected_count <= exp_next;
      received_count <= received_count_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      ready_flag     <= ready_flag_next;
    end
  end

  // Header and checksum byte captures
  always_ff @(posedge clk) begin
    if (accept && len_hi_we) begin
      len_hi <= rx_byte;
    end
    if (accept && len_lo_we) begin
      len_lo <= rx_byte;
    end
    if (accept && hdr_chk_we) begin
      hdr_chk_a <= rx_byte;
    end
    if (accept && data_chk_we) begin
      data_chk_a <= rx_byte;
    end
  end

endmodule

// ===== rtl/radio_frame_receiver.sv =====
// Radio frame receiver top level: parser, payload store and result stages.
// A result is registered into stage 1 and then into the output register.
// Throughput: one transaction per cycle unless out_ready stalls; the parser state
// updates in the accept cycle, the payload store read registers into stage two.
// in_ready follows out_ready whenever the output register holds a result.
// Reset (rst, synchronous) returns the parser to sync hunt; stored bytes are kept.
module radio_frame_receiver import frc_pkg::*; #(
  parameter int BUFFER_BYTES = 258
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [7:0]        rx_byte,
  input  logic [IDX_W-1:0]  read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_res,
  output logic              frame_ready,
  output logic [PLEN_W-1:0] payload_length,
  output logic [7:0]        read_data
);

  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W = $clog2(BUFFER_BYTES);

  logic              advance, accept;
  frc_result_t       result, s1_result;
  frc_status_t       status;
  logic [CNT_W-1:0]  exp_next;
  logic [PLEN_W-1:0] s1_len;
  logic              s1_valid, s1_rd_ok;
  logic              wr_en, rd_en, rd_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  logic [31:0]       ri_ext, exp_ext;

  // Pipeline moves whenever the output register is free or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  frc_parser #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .operation(operation),
    .rx_byte  (rx_byte),
    .result   (result),
    .exp_next (exp_next),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .status   (status)
  );

  // Readback address decode
  assign ri_ext  = 32'(read_index);
  assign exp_ext = 32'(exp_next);
  assign rd_ok   = (operation == OP_READ) && (ri_ext < BUFFER_BYTES);
  assign rd_en   = accept && rd_ok;
  assign rd_addr = ri_ext[ADDR_W-1:0];

  frc_payload_ram #(
    .DEPTH (BUFFER_BYTES),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (accept && wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Stage 1 and output valid control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= accept;
      out_valid <= s1_valid;
    end
  end

  // Stage 1 and output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_result      <= result;
      s1_len         <= exp_ext[PLEN_W-1:0];
      s1_rd_ok       <= rd_ok;
      event_res      <= s1_result.ev;
      frame_ready    <= s1_result.ready;
      payload_length <= s1_len;
      read_data      <= s1_rd_ok ? rd_data : 8'd0;
    end
  end

  // Ready flag and ready phase always agree
  a_ready_phase: assert property (@(posedge clk) disable iff (rst)
    status.ready_flag == (status.phase == PH_READY))
    else $error("ready flag and parser phase disagree");

  // While gathering payload the count stays below the expected length
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    status.phase == PH_DATA |-> status.recv_below_exp)
    else $error("payload count reached length without a frame verdict");

  // A good frame always reports the ready flag with it
  a_good_ready: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_result.ev == EV_FRAME_OK |-> s1_result.ready)
    else $error("frame good without ready flag");

  // An accepted clear leaves the parser hunting with no frame held
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_CLEAR |=> status.phase == PH_HUNT && !status.ready_flag)
    else $error("clear did not return parser to hunt");

endmodule
